>>> hw/rtl/floppy_controller_registers_unit_assert.svh
// Assertion macros shared by the floppy controller register unit.
`ifndef FLOPPY_CONTROLLER_REGISTERS_UNIT_ASSERT_SVH
`define FLOPPY_CONTROLLER_REGISTERS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/fcr_pkg.sv
// Types, codes and constants of the floppy controller register unit.
`timescale 1ns / 1ps

package fcr_pkg;

    localparam int BUFFER_DEPTH = 512;
    localparam int DATA_W       = 8;
    localparam int ADDR_W       = 4;
    localparam int OP_W         = 2;
    localparam int OFF_W        = 23;
    localparam int SECTOR_BYTES = 512;
    localparam int BUSY_READS_RST = 10;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 2'd0,
        OP_READ      = 2'd1,
        OP_DISK_BYTE = 2'd2,
        OP_DISK_ERR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_CONTROL = 2'd1,
        PEND_COMMAND = 2'd2
    } t_pend;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_FETCH = 2'd2,
        S_DONE  = 2'd3
    } t_state;

    // Register map
    localparam logic [ADDR_W-1:0] REG_CONTROL  = 4'd0;
    localparam logic [ADDR_W-1:0] REG_COMMAND  = 4'd1;
    localparam logic [ADDR_W-1:0] REG_STATUS_A = 4'd2;
    localparam logic [ADDR_W-1:0] REG_STATUS_B = 4'd3;
    localparam logic [ADDR_W-1:0] REG_TRACK    = 4'd4;
    localparam logic [ADDR_W-1:0] REG_SECTOR   = 4'd5;
    localparam logic [ADDR_W-1:0] REG_SIDE     = 4'd6;
    localparam logic [ADDR_W-1:0] REG_DATA     = 4'd7;
    localparam logic [ADDR_W-1:0] REG_CLOCK    = 4'd8;
    localparam logic [ADDR_W-1:0] REG_STEP     = 4'd9;
    localparam logic [ADDR_W-1:0] REG_RESERVED = 4'd10;

    // Configuration register indexes
    localparam logic CFG_DISK_PRESENT = 1'b0;
    localparam logic CFG_BUSY_READS   = 1'b1;

    // Command codes, upper five bits of the command register
    localparam logic [4:0] CMD_READ_SECTOR = 5'h08;  // 0x40
    localparam logic [4:0] CMD_WPROT       = 5'h10;  // 0x80
    localparam logic [4:0] CMD_STEP_OUT    = 5'h02;  // 0x10
    localparam logic [4:0] CMD_STEP_IN     = 5'h03;  // 0x18
    localparam logic [4:0] CMD_SPIN_UP     = 5'h04;  // 0x20

    // Status A bits
    localparam logic [DATA_W-1:0] SA_BUSY   = 8'h80;
    localparam logic [DATA_W-1:0] SA_DRQ    = 8'h40;
    localparam logic [DATA_W-1:0] SA_EQ     = 8'h20;
    localparam logic [DATA_W-1:0] SA_RNF    = 8'h10;
    localparam logic [DATA_W-1:0] SA_WPROT  = 8'h02;
    localparam logic [DATA_W-1:0] SA_TRACK0 = 8'h01;
    localparam logic [DATA_W-1:0] SA_CMD_CLR = 8'h1C;

    // Status B bits
    localparam logic [DATA_W-1:0] SB_RDREQ   = 8'h80;
    localparam logic [DATA_W-1:0] SB_WRREQ   = 8'h40;
    localparam logic [DATA_W-1:0] SB_DISKIN  = 8'h08;
    localparam logic [DATA_W-1:0] SB_RUN     = 8'h02;

    localparam logic [DATA_W-1:0] CTRL_MOTOR = 8'h20;

    localparam logic [DATA_W-1:0] STATUS_A_RST = 8'h01;
    localparam logic [DATA_W-1:0] STATUS_B_RST = 8'h08;
    localparam logic [DATA_W-1:0] HEAD_MAX     = 8'd128;
    localparam logic [DATA_W-1:0] BYTE_ONES    = 8'hFF;

    typedef struct packed {
        logic capture;
        logic exec;
        logic fetch;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic op_read;
    } t_dp_stat;

endpackage

>>> hw/rtl/floppy_controller_registers_unit.sv
// Top level of the floppy controller register unit.
`timescale 1ns / 1ps
`include "floppy_controller_registers_unit_assert.svh"

// Usage:
//   Command channel: drive i_operation, i_register_address and i_data_byte and
//   raise i_start; the beat is taken at the rising edge where i_start is high and
//   o_busy is low. Operations are register write, register read, disk data byte
//   and disk read error.
//   Result channel: every beat gives exactly one result, shown for one cycle with
//   o_strobe high: o_read_data for reads (zero otherwise), o_sector_request and
//   o_image_offset when a read-sector command ran with a disk attached.
//   The receiver cannot stall; it must take the result in the strobe cycle.
//   Sequencing: execute, a buffer fetch (register reads only), finish; the result
//   is registered from finish and the strobe cycle can accept the next beat. The
//   read path is set by the registered read port of the sector buffer RAM.
//   Configuration: i_cfg_we with i_cfg_index 0 (disk present) or 1 (busy read
//   count), data on i_cfg_data, written at the edge; the user must write it
//   only while idle, which the block itself does not enforce.
//   Reset (i_rst_n low, synchronous) restores state and status registers to their
//   power-up values at once; payload, result data and the sector buffer are kept.

module floppy_controller_registers_unit #(
    parameter int BUFFER_DEPTH = fcr_pkg::BUFFER_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [fcr_pkg::OP_W-1:0]           i_operation,
    input  logic [fcr_pkg::ADDR_W-1:0]         i_register_address,
    input  logic [fcr_pkg::DATA_W-1:0]         i_data_byte,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [fcr_pkg::DATA_W-1:0]         i_cfg_data,
    output logic                               o_strobe,
    output logic [fcr_pkg::DATA_W-1:0]         o_read_data,
    output logic                               o_sector_request,
    output logic signed [fcr_pkg::OFF_W-1:0]   o_image_offset
);

    fcr_pkg::t_dp_cmd  dp_cmd;
    fcr_pkg::t_dp_stat dp_stat;

    // sequencer: idle, execute, buffer fetch (reads only), finish
    fcr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (dp_stat),
        .o_busy  (o_busy),
        .o_cmd   (dp_cmd)
    );

    // registers, command execution, sector buffer and result registers
    fcr_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_stat             (dp_stat),
        .i_operation        (i_operation),
        .i_register_address (i_register_address),
        .i_data_byte        (i_data_byte),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_strobe           (o_strobe),
        .o_read_data        (o_read_data),
        .o_sector_request   (o_sector_request),
        .o_image_offset     (o_image_offset)
    );

    // an accepted beat keeps the unit busy next cycle
    `FCR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "not busy after accept")
    // the result shows while the sequencer is back in idle
    `FCR_ASSERT_SAME(a_strobe_idle, i_clk, i_rst_n, o_strobe, !o_busy, "strobe while busy")
    // a sector request only rides on a result beat
    `FCR_ASSERT_SAME(a_req_strobe, i_clk, i_rst_n, o_sector_request, o_strobe, "request without strobe")
    // each result is shown for a single cycle
    `FCR_ASSERT_NEXT(a_strobe_pulse, i_clk, i_rst_n, o_strobe, !o_strobe, "strobe longer than a cycle")

endmodule

>>> hw/rtl/fcr_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module fcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/fcr_ctrl.sv
// Sequencing state machine of the floppy controller register unit.
`timescale 1ns / 1ps

module fcr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  fcr_pkg::t_dp_stat i_stat,
    output logic              o_busy,
    output fcr_pkg::t_dp_cmd  o_cmd
);

    fcr_pkg::t_state r_state;
    fcr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            fcr_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = fcr_pkg::S_EXEC;
                end
            end
            fcr_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                // only register reads touch the buffer read port
                n_state = i_stat.op_read ? fcr_pkg::S_FETCH : fcr_pkg::S_DONE;
            end
            fcr_pkg::S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = fcr_pkg::S_DONE;
            end
            fcr_pkg::S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = fcr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/fcr_datapath.sv
// Register file, command execution and sector buffer of the floppy controller.
`timescale 1ns / 1ps

module fcr_datapath #(
    parameter int BUFFER_DEPTH = fcr_pkg::BUFFER_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fcr_pkg::t_dp_cmd                   i_cmd,
    output fcr_pkg::t_dp_stat                  o_stat,
    input  logic [fcr_pkg::OP_W-1:0]           i_operation,
    input  logic [fcr_pkg::ADDR_W-1:0]         i_register_address,
    input  logic [fcr_pkg::DATA_W-1:0]         i_data_byte,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [fcr_pkg::DATA_W-1:0]         i_cfg_data,
    output logic                               o_strobe,
    output logic [fcr_pkg::DATA_W-1:0]         o_read_data,
    output logic                               o_sector_request,
    output logic signed [fcr_pkg::OFF_W-1:0]   o_image_offset
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(BUFFER_DEPTH - 1);
    localparam int DW = fcr_pkg::DATA_W;
    localparam int OW = fcr_pkg::OFF_W;

    // architectural state
    logic [DW-1:0] r_control, n_control, r_command, n_command;
    logic [DW-1:0] r_status_a, n_status_a, r_status_b, n_status_b;
    logic [DW-1:0] r_track, n_track, r_sector, n_sector, r_side, n_side;
    logic [DW-1:0] r_clock, n_clock, r_step, n_step, r_head, n_head;
    logic [DW-1:0] r_busy_cnt, n_busy_cnt, r_busy_reads, n_busy_reads;
    logic          r_disk_present, n_disk_present;
    fcr_pkg::t_pend r_pend, n_pend;
    logic [PTR_W-1:0] r_host_ptr, n_host_ptr, r_drive_ptr, n_drive_ptr;

    // beat in flight
    fcr_pkg::t_op          r_op;
    logic [fcr_pkg::ADDR_W-1:0] r_addr;
    logic [DW-1:0]         r_data;
    logic                  r_req, n_req;
    logic [OW-1:0]         r_offset, n_offset;

    // result
    logic                  r_strobe, n_strobe;
    logic [DW-1:0]         r_read_data, n_read_data;
    logic                  r_sector_request, n_sector_request;
    logic [OW-1:0]         r_image_offset, n_image_offset;

    // buffer port
    logic          ram_we, ram_re;
    logic [DW-1:0] ram_rdata;

    // combinational temporaries
    logic [DW-1:0]    cnt_dec, head_dec, rd;
    logic [PTR_W-1:0] host_next;
    logic [OW-1:0]    trk_w, sec_w, side_w, offset_calc;

    fcr_ram #(
        .WIDTH (DW),
        .DEPTH (BUFFER_DEPTH)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_drive_ptr),
        .i_wdata (r_data),
        .i_re    (ram_re),
        .i_raddr (r_host_ptr),
        .o_rdata (ram_rdata)
    );

    assign o_stat.op_read = (r_op == fcr_pkg::OP_READ);

    // track*10240 + side*5120 + (sector-1)*512, mod 2^23 gives two's complement
    assign trk_w  = OW'(r_track);
    assign sec_w  = OW'(r_sector);
    assign side_w = OW'(r_side);
    assign offset_calc = (trk_w << 13) + (trk_w << 11) + (side_w << 12) + (side_w << 10)
                       + (sec_w << 9) - OW'(fcr_pkg::SECTOR_BYTES);

    assign host_next = (r_host_ptr == LAST_IDX) ? '0 : r_host_ptr + 1'b1;

    always_comb begin
        n_control      = r_control;
        n_command      = r_command;
        n_status_a     = r_status_a;
        n_status_b     = r_status_b;
        n_track        = r_track;
        n_sector       = r_sector;
        n_side         = r_side;
        n_clock        = r_clock;
        n_step         = r_step;
        n_head         = r_head;
        n_busy_cnt     = r_busy_cnt;
        n_busy_reads   = r_busy_reads;
        n_disk_present = r_disk_present;
        n_pend         = r_pend;
        n_host_ptr     = r_host_ptr;
        n_drive_ptr    = r_drive_ptr;
        n_req          = r_req;
        n_offset       = r_offset;
        n_strobe         = 1'b0;
        n_read_data      = '0;
        n_sector_request = 1'b0;
        n_image_offset   = '0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        cnt_dec  = '0;
        head_dec = '0;
        rd       = '0;

        if (i_cmd.exec) begin
            n_req    = 1'b0;
            n_offset = '0;
            unique case (r_op)
                fcr_pkg::OP_WRITE: begin
                    // a command write with a nonzero code while busy is dropped, countdown untouched
                    if (!(r_addr == fcr_pkg::REG_COMMAND
                          && (r_status_a & fcr_pkg::SA_BUSY) != '0
                          && r_data[7:3] != '0)) begin
                        unique case (r_addr)
                            fcr_pkg::REG_CONTROL: begin
                                n_control  = r_data;
                                n_status_a = n_status_a | fcr_pkg::SA_BUSY;
                                if (r_pend == fcr_pkg::PEND_NONE) begin
                                    n_pend = fcr_pkg::PEND_CONTROL;
                                end
                            end
                            fcr_pkg::REG_COMMAND: begin
                                n_command  = r_data;
                                n_pend     = fcr_pkg::PEND_COMMAND;
                                n_status_a = (n_status_a | fcr_pkg::SA_BUSY)
                                           & ~fcr_pkg::SA_CMD_CLR;
                                n_status_b = n_status_b
                                           & ~(fcr_pkg::SB_RUN | fcr_pkg::SB_RDREQ
                                               | fcr_pkg::SB_WRREQ);
                                if (r_data[7:3] == fcr_pkg::CMD_WPROT) begin
                                    n_status_a = n_status_a | fcr_pkg::SA_WPROT;
                                end else begin
                                    n_status_a = n_status_a & ~fcr_pkg::SA_WPROT;
                                end
                            end
                            fcr_pkg::REG_TRACK:  n_track  = r_data;
                            fcr_pkg::REG_SECTOR: n_sector = r_data;
                            fcr_pkg::REG_SIDE:   n_side   = r_data;
                            fcr_pkg::REG_CLOCK:  n_clock  = r_data;
                            fcr_pkg::REG_STEP:   n_step   = r_data;
                            default: ;
                        endcase
                        if ((n_status_a & fcr_pkg::SA_BUSY) != '0) begin
                            n_busy_cnt = r_busy_reads;
                        end
                    end
                end
                fcr_pkg::OP_READ: begin
                    if ((r_status_a & fcr_pkg::SA_BUSY) != '0) begin
                        cnt_dec    = (r_busy_cnt != '0) ? r_busy_cnt - 1'b1 : '0;
                        n_busy_cnt = cnt_dec;
                        if (cnt_dec == '0) begin
                            n_status_a = n_status_a & ~fcr_pkg::SA_BUSY;
                            n_status_b = n_status_b | fcr_pkg::SB_RUN;
                            // control-only mark survives until a command lands
                            if (r_pend == fcr_pkg::PEND_COMMAND) begin
                                n_pend = fcr_pkg::PEND_NONE;
                                unique case (r_command[7:3])
                                    fcr_pkg::CMD_READ_SECTOR: begin
                                        n_status_b = n_status_b | fcr_pkg::SB_RDREQ;
                                        n_status_a = (n_status_a | fcr_pkg::SA_DRQ)
                                                   & ~fcr_pkg::SA_EQ;
                                        if (r_disk_present) begin
                                            n_offset    = offset_calc;
                                            n_drive_ptr = '0;
                                            n_req       = 1'b1;
                                        end else begin
                                            n_status_a = n_status_a | fcr_pkg::SA_RNF;
                                            n_status_b = n_status_b & ~fcr_pkg::SB_DISKIN;
                                        end
                                        n_host_ptr = '0;
                                    end
                                    fcr_pkg::CMD_WPROT: begin
                                        n_status_a = n_status_a | fcr_pkg::SA_WPROT;
                                    end
                                    fcr_pkg::CMD_STEP_OUT: begin
                                        if (!r_command[2]) begin
                                            head_dec = (r_head != '0) ? r_head - 1'b1 : r_head;
                                            n_head   = head_dec;
                                            if (head_dec == '0) begin
                                                n_status_a = n_status_a | fcr_pkg::SA_TRACK0;
                                            end
                                        end
                                    end
                                    fcr_pkg::CMD_STEP_IN: begin
                                        if (r_head < fcr_pkg::HEAD_MAX) begin
                                            n_head = r_head + 1'b1;
                                        end
                                        n_status_a = n_status_a & ~fcr_pkg::SA_TRACK0;
                                    end
                                    fcr_pkg::CMD_SPIN_UP: begin
                                        n_control  = r_control | fcr_pkg::CTRL_MOTOR;
                                        n_status_a = n_status_a | fcr_pkg::SA_RNF;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                    end
                end
                fcr_pkg::OP_DISK_BYTE: begin
                    ram_we      = 1'b1;
                    n_drive_ptr = (r_drive_ptr == LAST_IDX) ? '0 : r_drive_ptr + 1'b1;
                end
                fcr_pkg::OP_DISK_ERR: begin
                    n_status_a = n_status_a | fcr_pkg::SA_RNF;
                end
            endcase
        end

        if (i_cmd.fetch) begin
            ram_re = 1'b1;
        end

        if (i_cmd.finish) begin
            if (r_op == fcr_pkg::OP_READ) begin
                unique case (r_addr)
                    fcr_pkg::REG_CONTROL:  rd = r_control;
                    fcr_pkg::REG_COMMAND:  rd = r_command;
                    fcr_pkg::REG_STATUS_A: rd = r_status_a;
                    fcr_pkg::REG_STATUS_B: rd = r_status_b;
                    fcr_pkg::REG_TRACK:    rd = r_track;
                    fcr_pkg::REG_SECTOR:   rd = r_sector;
                    fcr_pkg::REG_SIDE:     rd = r_side;
                    fcr_pkg::REG_DATA: begin
                        rd         = ram_rdata;
                        n_status_a = n_status_a & ~fcr_pkg::SA_DRQ;
                        n_status_b = n_status_b & ~fcr_pkg::SB_RDREQ;
                        n_host_ptr = host_next;
                        if (host_next == '0) begin
                            n_status_a = n_status_a | fcr_pkg::SA_EQ;
                        end else begin
                            n_status_a = n_status_a & ~fcr_pkg::SA_EQ;
                        end
                    end
                    fcr_pkg::REG_CLOCK:    rd = r_clock;
                    fcr_pkg::REG_STEP:     rd = r_step;
                    fcr_pkg::REG_RESERVED: rd = '0;
                    default:               rd = fcr_pkg::BYTE_ONES;
                endcase
            end
            n_strobe         = 1'b1;
            n_read_data      = rd;
            n_sector_request = r_req;
            n_image_offset   = r_req ? r_offset : '0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                fcr_pkg::CFG_DISK_PRESENT: n_disk_present = i_cfg_data[0];
                fcr_pkg::CFG_BUSY_READS:   n_busy_reads   = i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control      <= '0;
            r_command      <= '0;
            r_status_a     <= fcr_pkg::STATUS_A_RST;
            r_status_b     <= fcr_pkg::STATUS_B_RST;
            r_track        <= '0;
            r_sector       <= '0;
            r_side         <= '0;
            r_clock        <= fcr_pkg::BYTE_ONES;
            r_step         <= fcr_pkg::BYTE_ONES;
            r_head         <= '0;
            r_busy_cnt     <= '0;
            r_busy_reads   <= DW'(fcr_pkg::BUSY_READS_RST);
            r_disk_present <= 1'b0;
            r_pend         <= fcr_pkg::PEND_NONE;
            r_host_ptr     <= '0;
            r_drive_ptr    <= '0;
            r_req          <= 1'b0;
            r_strobe       <= 1'b0;
        end else begin
            r_control      <= n_control;
            r_command      <= n_command;
            r_status_a     <= n_status_a;
            r_status_b     <= n_status_b;
            r_track        <= n_track;
            r_sector       <= n_sector;
            r_side         <= n_side;
            r_clock        <= n_clock;
            r_step         <= n_step;
            r_head         <= n_head;
            r_busy_cnt     <= n_busy_cnt;
            r_busy_reads   <= n_busy_reads;
            r_disk_present <= n_disk_present;
            r_pend         <= n_pend;
            r_host_ptr     <= n_host_ptr;
            r_drive_ptr    <= n_drive_ptr;
            r_req          <= n_req;
            r_strobe       <= n_strobe;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= fcr_pkg::t_op'(i_operation);
            r_addr <= i_register_address;
            r_data <= i_data_byte;
        end
        r_offset         <= n_offset;
        r_read_data      <= n_read_data;
        r_sector_request <= n_sector_request;
        r_image_offset   <= n_image_offset;
    end

    assign o_strobe         = r_strobe;
    assign o_read_data      = r_read_data;
    assign o_sector_request = r_sector_request & r_strobe;
    assign o_image_offset   = signed'(r_image_offset);

endmodule

>>> tb/floppy_controller_registers_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the floppy controller register unit.
module floppy_controller_registers_unit_test;
    import fcr_pkg::*;

    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int TRACK_BYTES  = 10240;   // one track, both sides
    localparam int SIDE_BYTES   = 5120;    // one side of a track
    localparam int IDLE_PCT     = 19;      // chance of a gap before a beat
    localparam int DRAIN_LIMIT  = 64;      // cycles allowed for results still in flight
    localparam int RUN_LIMIT_NS = 1_000_000;

    // Addresses outside the register map, and the cancel command code
    localparam logic [ADDR_W-1:0] REG_UNUSED_LO = 4'd11;
    localparam logic [ADDR_W-1:0] REG_UNUSED_HI = 4'd15;
    localparam logic [4:0]        CMD_CANCEL    = 5'h00;

    // What the block must answer for one beat
    typedef struct {
        logic [DATA_W-1:0]       read_data;
        logic                    sector_request;
        logic signed [OFF_W-1:0] image_offset;
    } t_bus_reply;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_start;
    logic                      o_busy;
    logic [OP_W-1:0]           i_operation;
    logic [ADDR_W-1:0]         i_register_address;
    logic [DATA_W-1:0]         i_data_byte;
    logic                      i_cfg_we;
    logic                      i_cfg_index;
    logic [DATA_W-1:0]         i_cfg_data;
    logic                      o_strobe;
    logic [DATA_W-1:0]         o_read_data;
    logic                      o_sector_request;
    logic signed [OFF_W-1:0]   o_image_offset;

    floppy_controller_registers_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_operation        (i_operation),
        .i_register_address (i_register_address),
        .i_data_byte        (i_data_byte),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_strobe           (o_strobe),
        .o_read_data        (o_read_data),
        .o_sector_request   (o_sector_request),
        .o_image_offset     (o_image_offset)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Controller shadow: register file, countdown, sector buffer.
    // Declaration values are the power-up state.
    // ------------------------------------------------------------------
    logic              m_disk_present = 1'b0;
    logic [DATA_W-1:0] m_busy_reads   = 8'(BUSY_READS_RST);

    logic [DATA_W-1:0] m_ctrl   = '0;
    logic [DATA_W-1:0] m_cmd    = '0;
    logic [DATA_W-1:0] m_sta    = STATUS_A_RST;
    logic [DATA_W-1:0] m_stb    = STATUS_B_RST;
    logic [DATA_W-1:0] m_track  = '0;
    logic [DATA_W-1:0] m_sector = '0;
    logic [DATA_W-1:0] m_side   = '0;
    logic [DATA_W-1:0] m_clock  = BYTE_ONES;
    logic [DATA_W-1:0] m_step   = BYTE_ONES;
    logic [DATA_W-1:0] m_head   = '0;
    t_pend             m_pend   = PEND_NONE;
    logic [DATA_W-1:0] m_busy_cnt = '0;
    logic [DATA_W-1:0] m_buf [BUFFER_DEPTH];
    bit                m_buf_valid [BUFFER_DEPTH];   // entry written since power-up
    logic [PTR_W-1:0]  m_host_ptr  = '0;
    logic [PTR_W-1:0]  m_drive_ptr = '0;

    t_bus_reply bus_replies_q[$];   // answers owed by the block, oldest first
    int         g_errors  = 0;
    int         g_beats   = 0;      // beats taken by the block
    int         g_checked = 0;      // results compared so far
    bit         g_steady  = 1'b0;   // no gaps between beats while set

    // Applies one accepted beat to the shadow and returns the answer it owes.
    function automatic t_bus_reply fdc_access(t_op op, logic [ADDR_W-1:0] addr,
                                              logic [DATA_W-1:0] data);
        t_bus_reply reply;
        bit         ignored;
        int         offset;

        reply.read_data      = '0;
        reply.sector_request = 1'b0;
        reply.image_offset   = '0;
        ignored              = 1'b0;

        case (op)
            OP_WRITE: begin
                case (addr)
                    REG_CONTROL: begin
                        m_ctrl = data;
                        m_sta |= SA_BUSY;
                        if (m_pend == PEND_NONE) m_pend = PEND_CONTROL;
                    end
                    REG_COMMAND: begin
                        // a real command is refused while BUSY; low-bit-only writes pass
                        if ((m_sta & SA_BUSY) != 0 && data[7:3] != '0) begin
                            ignored = 1'b1;
                        end else begin
                            m_cmd  = data;
                            m_pend = PEND_COMMAND;
                            m_sta |= SA_BUSY;
                            m_stb &= ~SB_RUN;
                            m_sta &= ~SA_CMD_CLR;
                            m_stb &= ~(SB_RDREQ | SB_WRREQ);
                            if (data[7:3] == CMD_WPROT) m_sta |= SA_WPROT;
                            else m_sta &= ~SA_WPROT;
                        end
                    end
                    REG_TRACK:  m_track  = data;
                    REG_SECTOR: m_sector = data;
                    REG_SIDE:   m_side   = data;
                    REG_CLOCK:  m_clock  = data;
                    REG_STEP:   m_step   = data;
                    default: ;
                endcase
                // any accepted write restarts the countdown while BUSY
                if (!ignored && (m_sta & SA_BUSY) != 0) m_busy_cnt = m_busy_reads;
            end
            OP_READ: begin
                if ((m_sta & SA_BUSY) != 0) begin
                    if (m_busy_cnt != 0) m_busy_cnt--;
                    if (m_busy_cnt == 0) begin
                        m_sta &= ~SA_BUSY;
                        m_stb |= SB_RUN;
                        // control-only pending just drops BUSY and keeps its mark
                        if (m_pend == PEND_COMMAND) begin
                            case (m_cmd[7:3])
                                CMD_READ_SECTOR: begin
                                    m_stb |= SB_RDREQ;
                                    m_sta |= SA_DRQ;
                                    m_sta &= ~SA_EQ;
                                    if (m_disk_present) begin
                                        offset = int'(m_track) * TRACK_BYTES
                                               + (int'(m_sector) - 1) * SECTOR_BYTES
                                               + int'(m_side) * SIDE_BYTES;
                                        reply.sector_request = 1'b1;
                                        reply.image_offset   = offset[OFF_W-1:0];
                                        m_drive_ptr = '0;
                                    end else begin
                                        m_sta |= SA_RNF;
                                        m_stb &= ~SB_DISKIN;
                                    end
                                    m_host_ptr = '0;
                                end
                                CMD_WPROT: m_sta |= SA_WPROT;
                                CMD_STEP_OUT: begin
                                    // bit 2 holds the head where it is
                                    if (!m_cmd[2]) begin
                                        if (m_head != 0) m_head--;
                                        if (m_head == 0) m_sta |= SA_TRACK0;
                                    end
                                end
                                CMD_STEP_IN: begin
                                    if (m_head < HEAD_MAX) m_head++;
                                    m_sta &= ~SA_TRACK0;
                                end
                                CMD_SPIN_UP: begin
                                    m_ctrl |= CTRL_MOTOR;
                                    m_sta  |= SA_RNF;
                                end
                                default: ;   // cancel and unknown codes
                            endcase
                            m_pend = PEND_NONE;
                        end
                    end
                end
                case (addr)
                    REG_CONTROL:  reply.read_data = m_ctrl;
                    REG_COMMAND:  reply.read_data = m_cmd;
                    REG_STATUS_A: reply.read_data = m_sta;
                    REG_STATUS_B: reply.read_data = m_stb;
                    REG_TRACK:    reply.read_data = m_track;
                    REG_SECTOR:   reply.read_data = m_sector;
                    REG_SIDE:     reply.read_data = m_side;
                    REG_DATA: begin
                        m_sta &= ~SA_DRQ;
                        m_stb &= ~SB_RDREQ;
                        reply.read_data = m_buf[m_host_ptr];
                        m_host_ptr++;
                        if (m_host_ptr == 0) m_sta |= SA_EQ;
                        else m_sta &= ~SA_EQ;
                    end
                    REG_CLOCK:    reply.read_data = m_clock;
                    REG_STEP:     reply.read_data = m_step;
                    REG_RESERVED: reply.read_data = '0;
                    default:      reply.read_data = BYTE_ONES;
                endcase
            end
            OP_DISK_BYTE: begin
                m_buf[m_drive_ptr]       = data;
                m_buf_valid[m_drive_ptr] = 1'b1;
                m_drive_ptr++;
            end
            default: m_sta |= SA_RNF;   // disk read error
        endcase
        return reply;
    endfunction

    task automatic report_fail(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        g_errors++;
    endtask

    // ------------------------------------------------------------------
    // Result checker. The receiver cannot stall, so every strobe cycle is
    // taken at the edge that ends it and matched against the oldest answer.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_bus_reply want;
        if (i_rst_n && o_strobe) begin
            if (bus_replies_q.size() == 0) begin
                report_fail("result strobe with no beat outstanding");
            end else begin
                want = bus_replies_q.pop_front();
                if (o_read_data !== want.read_data)
                    report_fail($sformatf("result %0d read_data %02h, expected %02h",
                                          g_checked, o_read_data, want.read_data));
                if (o_sector_request !== want.sector_request)
                    report_fail($sformatf("result %0d sector_request %b, expected %b",
                                          g_checked, o_sector_request,
                                          want.sector_request));
                if (o_image_offset !== want.image_offset)
                    report_fail($sformatf("result %0d image_offset %0d, expected %0d",
                                          g_checked, o_image_offset, want.image_offset));
                g_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Command beat driver. i_start stays high after an accepted beat so that
    // back-to-back beats need only one assignment per edge; drain_results
    // drops it when a phase ends.
    // ------------------------------------------------------------------
    task automatic send_beat(t_op op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        logic [PTR_W-1:0] rd_ptr;
        // A data read must hit a buffer entry written since power-up. The read
        // may first run a pending read-sector, which rewinds the host pointer.
        if (op == OP_READ && addr == REG_DATA) begin
            rd_ptr = m_host_ptr;
            if ((m_sta & SA_BUSY) != 0 && m_busy_cnt <= 1 && m_pend == PEND_COMMAND
                && m_cmd[7:3] == CMD_READ_SECTOR)
                rd_ptr = '0;
            if (!m_buf_valid[rd_ptr]) addr = REG_STATUS_A;
        end
        if (!g_steady && $urandom_range(99) < IDLE_PCT) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_start            <= 1'b1;
        i_operation        <= op;
        i_register_address <= addr;
        i_data_byte        <= data;
        // o_busy here is the value before the edge: low means the beat was taken
        do @(posedge i_clk); while (o_busy);
        bus_replies_q.push_back(fdc_access(op, addr, data));
        g_beats++;
    endtask

    // Ends a phase: no more beats, every answer back, then the bench idles a while.
    task automatic drain_results();
        int waited;
        waited = 0;
        i_start <= 1'b0;
        while (bus_replies_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (bus_replies_q.size() != 0) begin
            report_fail($sformatf("%0d results never arrived", bus_replies_q.size()));
            bus_replies_q.delete();
        end
        repeat (6) @(posedge i_clk);
    endtask

    // Writes both configuration registers; only called with the block idle.
    task automatic set_mode(logic disk, logic [DATA_W-1:0] busy_reads);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DISK_PRESENT;
        i_cfg_data  <= {7'd0, disk};
        @(posedge i_clk);
        i_cfg_index <= CFG_BUSY_READS;
        i_cfg_data  <= busy_reads;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        m_disk_present  = disk;
        m_busy_reads    = busy_reads;
    endtask

    // Reads status until the pending command or control write has run.
    task automatic poll_until_idle();
        while ((m_sta & SA_BUSY) != 0) begin
            case ($urandom_range(4))
                3:       send_beat(OP_READ, REG_STATUS_B, 8'($urandom));
                4:       send_beat(OP_READ, 4'($urandom), 8'($urandom));
                default: send_beat(OP_READ, REG_STATUS_A, 8'($urandom));
            endcase
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_edge_byte();
        case ($urandom_range(5))
            0:       return '0;
            1:       return BYTE_ONES;
            default: return 8'($urandom);
        endcase
    endfunction

    // Set up a sector, run read-sector, feed disk bytes, drain the buffer.
    task automatic sector_transfer(bit full);
        int n_bytes;
        int n_reads;
        logic [DATA_W-1:0] sector;

        case ($urandom_range(9))
            0:       sector = '0;         // offset can go negative
            1:       sector = BYTE_ONES;
            default: sector = 8'($urandom_range(1, 20));
        endcase
        poll_until_idle();
        send_beat(OP_WRITE, REG_TRACK, pick_edge_byte());
        send_beat(OP_WRITE, REG_SECTOR, sector);
        send_beat(OP_WRITE, REG_SIDE, pick_edge_byte());
        if ($urandom_range(4) == 0)
            send_beat(OP_WRITE, $urandom_range(1) ? REG_CLOCK : REG_STEP, 8'($urandom));
        // occasionally a control write first, so the command hits BUSY and is dropped
        if ($urandom_range(9) == 0)
            send_beat(OP_WRITE, REG_CONTROL, 8'($urandom));
        send_beat(OP_WRITE, REG_COMMAND, {CMD_READ_SECTOR, 3'($urandom)});
        poll_until_idle();

        n_bytes = full ? BUFFER_DEPTH + $urandom_range(8) : $urandom_range(1, 32);
        for (int i = 0; i < n_bytes; i++) begin
            if ($urandom_range(49) == 0)
                send_beat(OP_DISK_ERR, 4'($urandom), 8'($urandom));
            send_beat(OP_DISK_BYTE, 4'($urandom), 8'($urandom));
        end
        n_reads = full ? BUFFER_DEPTH + $urandom_range(2) : $urandom_range(n_bytes + 2);
        for (int i = 0; i < n_reads; i++) begin
            if ($urandom_range(9) == 0)
                send_beat(OP_READ, $urandom_range(1) ? REG_STATUS_A : REG_STATUS_B,
                          8'($urandom));
            else
                send_beat(OP_READ, REG_DATA, 8'($urandom));
        end
    endtask

    // Head, spin-up, write-protect, cancel, unknown and control-only commands, unmapped writes.
    task automatic head_command();
        logic [4:0] code;
        poll_until_idle();
        case ($urandom_range(7))
            0: code = CMD_STEP_IN;
            1: code = CMD_STEP_OUT;
            2: code = CMD_SPIN_UP;
            3: code = CMD_WPROT;
            4: code = CMD_CANCEL;
            5: code = 5'($urandom);
            default: code = CMD_CANCEL;
        endcase
        case ($urandom_range(9))
            0:       send_beat(OP_WRITE, REG_CONTROL, 8'($urandom));
            1:       send_beat(OP_WRITE, REG_UNUSED_LO + 4'($urandom_range(4)), 8'($urandom));
            default: send_beat(OP_WRITE, REG_COMMAND, {code, 3'($urandom)});
        endcase
        if ($urandom_range(3) == 0)
            send_beat(OP_WRITE, $urandom_range(1) ? REG_CLOCK : REG_STEP, 8'($urandom));
        poll_until_idle();
        if ($urandom_range(1) == 0)
            send_beat(OP_READ, $urandom_range(1) ? REG_CONTROL : REG_COMMAND, 8'($urandom));
    endtask

    // Fully random beats: any operation, any address, any data.
    task automatic noise_burst();
        repeat ($urandom_range(1, 6))
            send_beat(t_op'($urandom_range(3)), 4'($urandom), 8'($urandom));
    endtask

    // Mostly well-formed command sequences, with some noise mixed in.
    task automatic run_traffic(int n_beats);
        int target;
        int pick;
        target = g_beats + n_beats;
        while (g_beats < target) begin
            pick = $urandom_range(99);
            if (pick < 60)      sector_transfer($urandom_range(49) == 0);
            else if (pick < 85) head_command();
            else                noise_burst();
        end
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Every register but the data register after power-up, plus the reserved and unmapped reads.
    task automatic test_reset_values();
        for (int a = 0; a <= REG_UNUSED_HI; a++)
            if (a != REG_DATA) send_beat(OP_READ, 4'(a), 8'($urandom));
        drain_results();
    endtask

    // Read-sector with no disk: RNF up, disk-inserted down, no request.
    task automatic test_read_without_disk();
        set_mode(1'b0, 8'd1);
        send_beat(OP_WRITE, REG_TRACK, BYTE_ONES);
        send_beat(OP_WRITE, REG_SECTOR, '0);
        send_beat(OP_WRITE, REG_SIDE, BYTE_ONES);
        send_beat(OP_WRITE, REG_COMMAND, {CMD_READ_SECTOR, 3'b000});
        send_beat(OP_READ, REG_STATUS_A, '0);
        send_beat(OP_READ, REG_STATUS_B, BYTE_ONES);
        drain_results();
    endtask

    // Command refused while BUSY; unmapped write still restarts the countdown;
    // control-only pending just drops BUSY.
    task automatic test_busy_guard();
        send_beat(OP_WRITE, REG_CONTROL, BYTE_ONES);
        send_beat(OP_WRITE, REG_COMMAND, {CMD_WPROT, 3'b000});
        send_beat(OP_WRITE, REG_UNUSED_LO, 8'h5A);
        send_beat(OP_READ, REG_COMMAND, '0);
        send_beat(OP_READ, REG_STATUS_A, '0);
        drain_results();
    endtask

    // Disk bytes at the data extremes and a disk read error.
    task automatic test_disk_side();
        send_beat(OP_DISK_BYTE, '0, '0);
        send_beat(OP_DISK_BYTE, REG_UNUSED_HI, BYTE_ONES);
        send_beat(OP_DISK_ERR, '0, '0);
        send_beat(OP_READ, REG_STATUS_A, '0);
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Random tests, each under its own configuration
    // ------------------------------------------------------------------

    // Disk present, shortest countdown, no gaps at all; one whole sector first.
    task automatic test_steady_traffic();
        set_mode(1'b1, 8'd1);
        g_steady = 1'b1;
        sector_transfer(1'b1);
        run_traffic(40);
        g_steady = 1'b0;
        drain_results();
    endtask

    task automatic test_mixed_traffic();
        set_mode(1'b1, 8'($urandom_range(2, 12)));
        run_traffic(80);
        drain_results();
    endtask

    task automatic test_no_disk_traffic();
        set_mode(1'b0, 8'd3);
        run_traffic(40);
        drain_results();
    endtask

    // Head to the inner stop and back to track zero; countdown of zero acts as one.
    task automatic test_head_travel();
        set_mode(1'b1, '0);
        repeat (HEAD_MAX + 2) begin
            send_beat(OP_WRITE, REG_COMMAND, {CMD_STEP_IN, 3'($urandom)});
            poll_until_idle();
        end
        repeat (HEAD_MAX + 2) begin
            // bit 2 clear so every step-out really moves
            send_beat(OP_WRITE, REG_COMMAND, {CMD_STEP_OUT, 1'b0, 2'($urandom)});
            poll_until_idle();
        end
        drain_results();
    endtask

    // Longest countdown: each command waits out 255 register reads.
    task automatic test_long_countdown();
        set_mode(1'b1, BYTE_ONES);
        sector_transfer(1'b0);
        drain_results();
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_start            <= 1'b0;
        i_operation        <= OP_WRITE;
        i_register_address <= '0;
        i_data_byte        <= '0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= CFG_DISK_PRESENT;
        i_cfg_data         <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_read_without_disk();
        test_busy_guard();
        test_disk_side();
        test_steady_traffic();
        test_mixed_traffic();
        test_no_disk_traffic();
        test_head_travel();
        test_long_countdown();

        repeat (8) @(posedge i_clk);
        if (g_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run
    initial begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/fcr_pkg.sv
hw/rtl/fcr_ram.sv
hw/rtl/fcr_ctrl.sv
hw/rtl/fcr_datapath.sv
hw/rtl/floppy_controller_registers_unit.sv
tb/floppy_controller_registers_unit_test.sv
